// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define ASSERT_AT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: %m");

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `ASSERT_AT_CLK(lbl, clk, rst_n, !(expr))

`endif

// ===== rtl/core/stsplit_pkg.sv =====
// Types and constants of the shell token splitter
`timescale 1ns / 1ps
`default_nettype none

package stsplit_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_end;
    } t_tok_in;

    typedef struct packed {
        logic [7:0] char_out;
        logic       has_char;
        logic       token_start;
        logic       token_end;
        logic       is_operator;
        logic       run_last;
    } t_tok_out;

    // held redirection operator
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_LT   = 2'd1;
    localparam logic [1:0] PEND_GT   = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    localparam t_tok_out RES_NONE = '0;

endpackage

`default_nettype wire

// ===== rtl/core/shell_token_splitter_core.sv =====
// Shell command-line token splitter: one byte in, up to two token words out
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+---------------------------
//  input   | i_in_valid  | o_in_stall   | i_in_data  (t_tok_in)
//  output  | o_out_valid | i_out_stall  | o_out_data (t_tok_out)
//
// A byte is registered on entry and split, once the queue has room, into
// 0..2 words that go to a 4-entry result queue. One byte per cycle is taken
// while the queue has room for two words; the output drains one word per
// cycle while i_out_stall is low, so bytes that give two words set the pace.
// Synchronous active-low reset empties the queue and clears quote state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module shell_token_splitter_core
    import stsplit_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_tok_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_tok_out      o_out_data,
    input  wire logic     i_out_stall
);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // tokenizer state
    logic       r_sq, r_dq, r_word_open;
    logic [1:0] r_pend;
    logic       n_sq, n_dq, n_word_open;
    logic [1:0] n_pend;

    // input register
    logic       r_in_valid;
    t_tok_in    r_in;

    // result queue
    t_tok_out         r_q [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QAW:0]     r_count;

    logic in_fire, proc_fire, out_fire, q_room;

    assign q_room     = (r_count <= (QAW+1)'(QDEPTH - 2));
    assign proc_fire  = r_in_valid && q_room;
    assign o_in_stall = r_in_valid && !q_room;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_q[r_rd_ptr];
    assign out_fire    = o_out_valid && !i_out_stall;

    // ---------------- split logic ----------------
    logic [7:0] c;
    logic       eol, is_space, is_op, is_quote_tgl;
    logic [7:0] held;

    assign c   = r_in.char_in;
    assign eol = r_in.is_end || (c == CH_NUL);
    assign is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                      (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    assign is_op    = (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT);
    assign is_quote_tgl = (c == CH_SQUOT && !r_dq) || (c == CH_DQUOT && !r_sq);
    // code 3 never arises; it reads as a held '>'
    assign held = (r_pend == PEND_LT) ? CH_LT : CH_GT;

    // new token from this byte with nothing open
    logic       st_emit, st_word, st_sq, st_dq;
    logic [1:0] st_pend;
    t_tok_out   st_res;

    always_comb begin
        st_emit = 1'b0;
        st_word = 1'b0;
        st_pend = PEND_NONE;
        st_sq   = r_sq;
        st_dq   = r_dq;
        st_res  = RES_NONE;
        if (!is_space) begin
            if (!r_sq && !r_dq && is_op) begin
                if (c == CH_PIPE) begin
                    st_emit = 1'b1;
                    st_res  = '{char_out: c, has_char: 1'b1, token_start: 1'b1,
                                token_end: 1'b1, is_operator: 1'b1, run_last: 1'b0};
                end else begin
                    st_pend = (c == CH_LT) ? PEND_LT : PEND_GT;
                end
            end else begin
                if (c == CH_SQUOT && !r_dq) begin
                    st_sq = !r_sq;
                end else if (c == CH_DQUOT && !r_sq) begin
                    st_dq = !r_dq;
                end
                st_emit = 1'b1;
                st_word = 1'b1;
                st_res  = '{char_out: c, has_char: 1'b1, token_start: 1'b1,
                            token_end: 1'b0, is_operator: 1'b0, run_last: 1'b0};
            end
        end
    end

    t_tok_out   res0, res1, close_res;
    logic [1:0] n_res;

    assign close_res = '{char_out: CH_NUL, has_char: 1'b0, token_start: 1'b0,
                         token_end: 1'b1, is_operator: 1'b0, run_last: 1'b0};

    always_comb begin
        n_sq        = r_sq;
        n_dq        = r_dq;
        n_word_open = r_word_open;
        n_pend      = r_pend;
        res0        = RES_NONE;
        res1        = RES_NONE;
        n_res       = 2'd0;
        if (r_pend != PEND_NONE) begin
            n_pend = PEND_NONE;
            if (!eol && c == held) begin
                res0  = '{char_out: held, has_char: 1'b1, token_start: 1'b1,
                          token_end: 1'b0, is_operator: 1'b1, run_last: 1'b0};
                res1  = '{char_out: c, has_char: 1'b1, token_start: 1'b0,
                          token_end: 1'b1, is_operator: 1'b1, run_last: 1'b0};
                n_res = 2'd2;
            end else begin
                res0  = '{char_out: held, has_char: 1'b1, token_start: 1'b1,
                          token_end: 1'b1, is_operator: 1'b1, run_last: 1'b0};
                n_res = 2'd1;
                if (!eol) begin
                    n_sq        = st_sq;
                    n_dq        = st_dq;
                    n_word_open = st_word;
                    n_pend      = st_pend;
                    if (st_emit) begin
                        res1  = st_res;
                        n_res = 2'd2;
                    end
                end
            end
        end else if (r_word_open) begin
            n_res = 2'd1;
            if (eol) begin
                res0        = close_res;
                n_word_open = 1'b0;
            end else if (is_quote_tgl) begin
                if (c == CH_SQUOT) begin
                    n_sq = !r_sq;
                end else begin
                    n_dq = !r_dq;
                end
                res0 = '{char_out: c, has_char: 1'b1, token_start: 1'b0,
                         token_end: 1'b0, is_operator: 1'b0, run_last: 1'b0};
            end else if (!r_sq && !r_dq && (is_space || is_op)) begin
                // word ends here; an operator then starts its own token
                res0        = close_res;
                n_word_open = st_word;
                n_pend      = st_pend;
                if (st_emit) begin
                    res1  = st_res;
                    n_res = 2'd2;
                end
            end else begin
                res0 = '{char_out: c, has_char: 1'b1, token_start: 1'b0,
                         token_end: 1'b0, is_operator: 1'b0, run_last: 1'b0};
            end
        end else if (!eol) begin
            n_sq        = st_sq;
            n_dq        = st_dq;
            n_word_open = st_word;
            n_pend      = st_pend;
            if (st_emit) begin
                res0  = st_res;
                n_res = 2'd1;
            end
        end
        if (n_res == 2'd2) begin
            res1.run_last = 1'b1;
        end else begin
            res0.run_last = 1'b1;
        end
    end

    // ---------------- registers ----------------
    logic [QAW:0] push_cnt;
    assign push_cnt = proc_fire ? (QAW+1)'(n_res) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_sq        <= 1'b0;
            r_dq        <= 1'b0;
            r_word_open <= 1'b0;
            r_pend      <= PEND_NONE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end
            if (proc_fire) begin
                r_sq        <= n_sq;
                r_dq        <= n_dq;
                r_word_open <= n_word_open;
                r_pend      <= n_pend;
                r_wr_ptr    <= r_wr_ptr + QAW'(n_res);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + push_cnt - (QAW+1)'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
        if (proc_fire && n_res != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (proc_fire && n_res == 2'd2) begin
            r_q[r_wr_ptr + 1'b1] <= res1;
        end
    end

    // ---------------- checks ----------------
    `ASSERT_AT_CLK(a_q_bound, i_clk, i_rst_n, r_count <= (QAW+1)'(QDEPTH))
    `ASSERT_NEVER(a_pend_word, i_clk, i_rst_n, (r_pend != PEND_NONE) && r_word_open)
    `ASSERT_AT_CLK(a_pend_code, i_clk, i_rst_n,
        r_pend == PEND_NONE || r_pend == PEND_LT || r_pend == PEND_GT)
    `ASSERT_AT_CLK(a_stall_hold, i_clk, i_rst_n,
        (r_in_valid && !q_room) |=> (r_in_valid && $stable(r_in)))

endmodule

`default_nettype wire
